[design/mktc_pkg.sv]
`timescale 1ns / 1ps

package mktc_pkg;

  localparam int CountWidth = 16;
  localparam int CfgWidth   = 16;
  localparam int CmpWidth   = (CountWidth > CfgWidth) ? CountWidth : CfgWidth;
  localparam int CfgIdxWidth = 2;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_DOT  = 2'd1,
    PH_DASH = 2'd2,
    PH_GAP  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KEY_NONE    = 2'd0,
    KEY_PRESS   = 2'd1,
    KEY_RELEASE = 2'd2
  } key_event_e;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_DOT    = 3'd1,
    EV_DASH   = 3'd2,
    EV_LETTER = 3'd3,
    EV_WORD   = 3'd4
  } morse_event_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DOT_LIMIT  = 2'd0,
    REG_LETTER_GAP = 2'd1,
    REG_WORD_GAP   = 2'd2
  } cfg_reg_e;

  localparam logic [CfgWidth-1:0] DotLimitReset  = 16'd50;
  localparam logic [CfgWidth-1:0] LetterGapReset = 16'd100;
  localparam logic [CfgWidth-1:0] WordGapReset   = 16'd200;

  typedef struct packed {
    logic [CfgWidth-1:0] dot_limit;
    logic [CfgWidth-1:0] letter_gap;
    logic [CfgWidth-1:0] word_gap;
  } cfg_t;

endpackage

[design/mktc_cfg_regs.sv]
`timescale 1ns / 1ps

module mktc_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mktc_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [mktc_pkg::CfgWidth-1:0]      cfg_data_i,
  output mktc_pkg::cfg_t                     cfg_o
);
  import mktc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DOT_LIMIT:  cfg_d.dot_limit  = cfg_data_i;
        REG_LETTER_GAP: cfg_d.letter_gap = cfg_data_i;
        REG_WORD_GAP:   cfg_d.word_gap   = cfg_data_i;
        default:        cfg_d = cfg_q;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_limit  <= DotLimitReset;
      cfg_q.letter_gap <= LetterGapReset;
      cfg_q.word_gap   <= WordGapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/mktc_core.sv]
`timescale 1ns / 1ps

module mktc_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic [1:0]                  key_event_i,
  input  mktc_pkg::cfg_t              cfg_i,
  output logic [2:0]                  morse_event_o
);
  import mktc_pkg::*;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  phase_e                phase_q, phase_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [CountWidth-1:0] count_inc;
  logic [CmpWidth-1:0]   count_ext;
  logic                  is_press, is_release;
  logic                  reach_dot, reach_letter, reach_word;
  morse_event_e          event_d;

  assign count_inc  = (count_q != CountMax) ? count_q + 1'b1 : count_q;
  assign count_ext  = CmpWidth'(count_inc);
  assign is_press   = (key_event_i == KEY_PRESS);
  assign is_release = (key_event_i == KEY_RELEASE);

  assign reach_dot    = count_ext >= CmpWidth'(cfg_i.dot_limit);
  assign reach_letter = count_ext >= CmpWidth'(cfg_i.letter_gap);
  assign reach_word   = count_ext >= CmpWidth'(cfg_i.word_gap);

  always_comb begin
    phase_d = phase_q;
    count_d = count_inc;
    event_d = EV_NONE;
    case (phase_q)
      PH_WAIT: begin
        count_d = '0;
        if (is_press) begin
          phase_d = PH_DOT;
        end
      end
      PH_DOT: begin
        if (is_release) begin
          count_d = '0;
          phase_d = PH_GAP;
          event_d = EV_DOT;
        end else if (reach_dot) begin
          phase_d = PH_DASH;
        end
      end
      PH_DASH: begin
        if (is_release) begin
          count_d = '0;
          phase_d = PH_GAP;
          event_d = EV_DASH;
        end
      end
      PH_GAP: begin
        // timeout wins over any key event on the same tick
        if (reach_word) begin
          phase_d = PH_WAIT;
          event_d = EV_WORD;
        end else if (is_press) begin
          if (reach_letter) begin
            event_d = EV_LETTER;
          end
          count_d = '0;
          phase_d = PH_DOT;
        end
      end
      default: begin
        phase_d = PH_WAIT;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      count_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  assign morse_event_o = event_d;

  a_wait_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && phase_q == PH_WAIT |=> count_q == '0)
    else $error("count not cleared after waiting tick");

  a_word_returns_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && event_d == EV_WORD |=> phase_q == PH_WAIT)
    else $error("word gap did not return to waiting");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(phase_q) && $stable(count_q))
    else $error("state moved without a tick");

endmodule

[design/morse_key_timing_classifier_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// in        sink       in_valid_i / in_stall_o     key_event_i (2b)
// out       source     out_valid_o / out_stall_i   morse_event_o (3b)
// cfg       sink       cfg_valid_i / cfg_ready_o   cfg_index_i (2b), cfg_data_i (16b)
//
// One word per cycle sustained while the output does not stall; an accepted tick
// waits in the input register, is classified there and its result is loaded into
// the result register when the tick advances (input register, then classifier).
// Reset clears thresholds to 50/100/200, phase to waiting and the count to zero.
// A stall on the output holds the result register and backs up into the input
// register; the input stalls only when that register is full and cannot move.
module morse_key_timing_classifier_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         key_event_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         morse_event_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mktc_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [mktc_pkg::CfgWidth-1:0]      cfg_data_i
);
  import mktc_pkg::*;

  cfg_t       cfg;
  logic       s1_valid_q, s1_valid_d;
  logic [1:0] s1_key_q;
  logic       out_valid_q, out_valid_d;
  logic [2:0] event_q;
  logic [2:0] core_event;
  logic       advance;
  logic       in_accept;

  mktc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mktc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .key_event_i   (s1_key_q),
    .cfg_i         (cfg),
    .morse_event_o (core_event)
  );

  // advance the held tick when the result register is free or draining
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_key_q <= key_event_i;
    end
    if (advance) begin
      event_q <= core_event;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign morse_event_o = event_q;

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked word");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after advance");

  a_stalled_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(event_q))
    else $error("stalled result word changed");

endmodule

[tb/morse_key_timing_classifier_top_test.sv]
`timescale 1ns / 1ps

module morse_key_timing_classifier_top_test;
  import mktc_pkg::*;

  localparam logic [1:0] KeyUnused = 2'd3;
  localparam logic [CfgIdxWidth-1:0] RegUnused = 2'd3;
  localparam int unsigned CycleLimit = 5_000_000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandomTicksPerSet = 60;
  localparam int unsigned LongHoldTicks = 40;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_e;

  typedef struct {
    logic [1:0]   key;
    int unsigned  reps;
    bit           pinned;
    morse_event_e ev;
  } tick_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] key_event_i = KEY_NONE;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] morse_event_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = REG_DOT_LIMIT;
  logic [CfgWidth-1:0] cfg_data_i = '0;

  morse_key_timing_classifier_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .key_event_i  (key_event_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .morse_event_o(morse_event_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // shadow of the classifier
  logic [CfgWidth-1:0]   dot_limit = DotLimitReset;
  logic [CfgWidth-1:0]   letter_gap = LetterGapReset;
  logic [CfgWidth-1:0]   word_gap = WordGapReset;
  phase_e                key_phase = PH_WAIT;
  logic [CountWidth-1:0] ticks = '0;

  morse_event_e expected_events[$];
  morse_event_e want_ev;
  int unsigned  mismatches = 0;
  int unsigned  ticks_sent = 0;
  int unsigned  events_checked = 0;
  int unsigned  reg_writes = 0;
  int unsigned  events_seen[5] = '{0, 0, 0, 0, 0};
  int unsigned  cycles = 0;
  int unsigned  burst_left = 0;

  stall_mode_e  stall_mode = STALL_NONE;
  int unsigned  stall_left = 0;
  logic [7:0]   stall_mask = 8'h00;

  tick_row_t directed_ticks[25];
  cfg_t      threshold_sets[9];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("morse_key_timing_classifier_top regression: fail");
      $finish;
    end
  end

  // receiver: switch between no stall, random stall and a rotating mask
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      stall_left <= $urandom_range(20, 200);
      stall_mask <= 8'($urandom_range(0, 254));
    end else begin
      stall_left <= stall_left - 1;
      stall_mask <= {stall_mask[6:0], stall_mask[7]};
    end
    case (stall_mode)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_RANDOM: out_stall_i <= ($urandom_range(0, 99) < 40);
      default: out_stall_i <= stall_mask[0];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      events_checked++;
      if (morse_event_o <= EV_WORD) events_seen[morse_event_o]++;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected morse event, expected none, actual %0d",
                 $time, morse_event_o);
        mismatches++;
      end else begin
        want_ev = expected_events.pop_front();
        if (morse_event_o !== want_ev) begin
          $display("%0t: morse_event mismatch, expected %0d (%s), actual %0d",
                   $time, want_ev, want_ev.name(), morse_event_o);
          mismatches++;
        end
      end
    end
  end

  // advance the shadow machine by one tick and return its event
  function automatic morse_event_e classify_tick(input logic [1:0] key);
    morse_event_e ev;
    ev = EV_NONE;
    if (ticks != '1) ticks = ticks + 1'b1;
    case (key_phase)
      PH_WAIT: begin
        ticks = '0;
        if (key == KEY_PRESS) key_phase = PH_DOT;
      end
      PH_DOT: begin
        if (key == KEY_RELEASE) begin
          ticks = '0;
          key_phase = PH_GAP;
          ev = EV_DOT;
        end else if (ticks >= dot_limit) begin
          key_phase = PH_DASH;
        end
      end
      PH_DASH: begin
        if (key == KEY_RELEASE) begin
          ticks = '0;
          key_phase = PH_GAP;
          ev = EV_DASH;
        end
      end
      default: begin
        // timeout wins over any key event on the same tick
        if (ticks >= word_gap) begin
          key_phase = PH_WAIT;
          ev = EV_WORD;
        end else if (key == KEY_PRESS) begin
          if (ticks >= letter_gap) ev = EV_LETTER;
          ticks = '0;
          key_phase = PH_DOT;
        end
      end
    endcase
    return ev;
  endfunction

  task automatic send_tick(input logic [1:0] key, input bit pinned = 1'b0,
                           input morse_event_e pinned_ev = EV_NONE);
    int unsigned gap;
    morse_event_e ev;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        key_event_i <= 2'($urandom_range(0, 3));
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    key_event_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    ev = classify_tick(key);
    expected_events.push_back(pinned ? pinned_ev : ev);
    ticks_sent++;
  endtask

  // drain all pending words, then let the pipeline go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgWidth-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
    case (idx)
      REG_DOT_LIMIT: dot_limit = val;
      REG_LETTER_GAP: letter_gap = val;
      REG_WORD_GAP: word_gap = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input cfg_t cfg, input bit poke_unused);
    if (poke_unused) write_reg(RegUnused, 16'($urandom_range(0, 65535)));
    write_reg(REG_DOT_LIMIT, cfg.dot_limit);
    write_reg(REG_LETTER_GAP, cfg.letter_gap);
    write_reg(REG_WORD_GAP, cfg.word_gap);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly idle ticks, with an occasional stray code
  function automatic logic [1:0] idle_key(input logic [1:0] stray);
    return ($urandom_range(0, 11) == 0) ? stray : KEY_NONE;
  endfunction

  task automatic random_letters(input int unsigned n);
    int unsigned sent, hold, hold_max, gap, gap_max, i, burst;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        hold_max = (dot_limit > 20) ? 40 : 2 * dot_limit + 3;
        gap_max = (word_gap > 30) ? 60 : word_gap + 4;
        hold = $urandom_range(0, hold_max);
        gap = $urandom_range(0, gap_max);
        send_tick(KEY_PRESS);
        for (i = 0; i < hold; i++)
          send_tick(idle_key(($urandom_range(0, 1) != 0) ? KEY_PRESS : KeyUnused));
        send_tick(KEY_RELEASE);
        for (i = 0; i < gap; i++)
          send_tick(idle_key(($urandom_range(0, 1) != 0) ? KEY_RELEASE : KeyUnused));
        sent += hold + gap + 2;
      end else begin
        burst = $urandom_range(1, 6);
        for (i = 0; i < burst; i++) send_tick(2'($urandom_range(0, 3)));
        sent += burst;
      end
    end
  endtask

  initial begin
    int unsigned r, j;
    directed_ticks = '{
      '{KEY_NONE,    1,   1'b1, EV_NONE},
      '{KEY_RELEASE, 1,   1'b1, EV_NONE},
      '{KeyUnused,   1,   1'b1, EV_NONE},
      '{KEY_PRESS,   1,   1'b1, EV_NONE},
      '{KEY_PRESS,   1,   1'b1, EV_NONE},
      '{KeyUnused,   1,   1'b1, EV_NONE},
      '{KEY_RELEASE, 1,   1'b1, EV_DOT},
      '{KEY_RELEASE, 1,   1'b1, EV_NONE},
      '{KEY_PRESS,   1,   1'b1, EV_NONE},
      '{KEY_NONE,    49,  1'b1, EV_NONE},
      '{KEY_NONE,    1,   1'b1, EV_NONE},
      '{KEY_RELEASE, 1,   1'b1, EV_DASH},
      '{KEY_NONE,    99,  1'b1, EV_NONE},
      '{KEY_PRESS,   1,   1'b1, EV_LETTER},
      '{KEY_RELEASE, 1,   1'b1, EV_DOT},
      '{KEY_NONE,    199, 1'b1, EV_NONE},
      '{KEY_PRESS,   1,   1'b1, EV_WORD},
      '{KEY_RELEASE, 1,   1'b1, EV_NONE},
      '{KEY_PRESS,   1,   1'b1, EV_NONE},
      '{KEY_NONE,    70,  1'b1, EV_NONE},
      '{KEY_RELEASE, 1,   1'b1, EV_DASH},
      '{KEY_NONE,    98,  1'b1, EV_NONE},
      '{KEY_PRESS,   1,   1'b1, EV_NONE},
      '{KEY_RELEASE, 1,   1'b1, EV_DOT},
      '{KEY_NONE,    230, 1'b0, EV_NONE}
    };
    threshold_sets = '{
      '{16'd2, 16'd4, 16'd9},
      '{16'd0, 16'd0, 16'd5},
      '{16'd1, 16'd1, 16'd1},
      '{16'd3, 16'd0, 16'd0},
      '{16'd5, 16'd9, 16'd3},
      '{16'd0, 16'd3, 16'd0},
      '{16'd4, 16'd6, 16'd12},
      '{16'd0, 16'd0, 16'd0},
      '{16'd0, 16'd0, 16'd0}
    };
    for (j = 7; j < 9; j++)
      threshold_sets[j] = '{16'($urandom_range(0, 10)), 16'($urandom_range(0, 14)),
                            16'($urandom_range(0, 20))};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds: hand-checked boundaries
    foreach (directed_ticks[i])
      for (r = 0; r < directed_ticks[i].reps; r++)
        send_tick(directed_ticks[i].key, directed_ticks[i].pinned, directed_ticks[i].ev);
    settle();

    foreach (threshold_sets[i]) begin
      set_thresholds(threshold_sets[i], i == 2);
      random_letters(RandomTicksPerSet);
      settle();
    end

    // maximum thresholds: a long press stays a dot and the gap does not time out
    set_thresholds('{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    send_tick(KEY_PRESS);
    for (r = 0; r < LongHoldTicks; r++) send_tick(KEY_NONE);
    send_tick(KEY_RELEASE);
    for (r = 0; r < LongHoldTicks; r++) send_tick(KEY_NONE);
    settle();

    $display("Sent %0d key ticks over %0d register writes; checked %0d events.",
             ticks_sent, reg_writes, events_checked);
    $display("Seen: %0d dot, %0d dash, %0d letter gap, %0d word gap, %0d mismatches.",
             events_seen[EV_DOT], events_seen[EV_DASH], events_seen[EV_LETTER],
             events_seen[EV_WORD], mismatches);
    if (mismatches == 0) begin
      $display("morse_key_timing_classifier_top regression: pass");
    end else begin
      $display("morse_key_timing_classifier_top regression: fail");
    end
    $finish;
  end

endmodule

[morse_key_timing_classifier_top.f]
design/mktc_pkg.sv
design/mktc_cfg_regs.sv
design/mktc_core.sv
design/morse_key_timing_classifier_top.sv
tb/morse_key_timing_classifier_top_test.sv
